// ===== rtl/first_fit_heap_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Shared property forms for the allocator's checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication under reset.
`define FFHA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication under reset.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Constants and codes shared by the allocator and its checker.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HEADER_BYTES = 8;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_BAD    = 2'd2
  } status_e;

endpackage

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int W = 14,
  parameter int D = 4096
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// Each transaction walks the chain of headers, one header a cycle: an operation walk
// (skipped for a free whose offset is rejected at acceptance) and then a usage walk.
// No new transaction is taken until the result: busy stays high until then, and a
// walk of up to arena/8 headers through the RAM read port sets how long it lasts.
// Reset: one cycle writes the single free header before busy falls.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Walks boundary headers in a RAM to allocate, free and report usage.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int ARENA_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        arena_size_we_i,
  input  logic [12:0] arena_size_i,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [12:0] req_size_i,
  input  logic [11:0] user_offset_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [11:0] position_o,
  output logic [9:0]  used_blocks_o,
  output logic [12:0] used_bytes_o,
  output logic [12:0] largest_free_o
);

  localparam int SW = $clog2(ARENA_BYTES + 1);
  localparam int AW = $clog2(ARENA_BYTES);
  localparam int CW = ((SW > 13) ? SW : 13) + 1;
  localparam int HW = SW + 1;
  localparam int RST_A = (ARENA_BYTES < 4096) ? ARENA_BYTES : 4096;
  localparam logic [SW-1:0] RST_ARENA = SW'(RST_A);
  localparam logic [CW-1:0] HB = CW'(HEADER_BYTES);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_OPW   = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_FNEXT = 3'd4;
  localparam logic [2:0] S_SISS  = 3'd5;
  localparam logic [2:0] S_STW   = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [SW-1:0] arena_q, arena_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [SW-1:0] prev_q, prev_d, psz_q, psz_d;
  logic          pfree_q, pfree_d;
  logic [SW-1:0] tgt_q, tgt_d, bsz_q, bsz_d;
  logic          hnext_q, hnext_d;
  logic          mode_q, mode_d;
  logic [12:0]   req_q, req_d;
  logic [1:0]    st_q, st_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] ub_q, ub_d, ubytes_q, ubytes_d, lf_q, lf_d;
  logic          rv_q, rv_d;
  logic [1:0]    ost_q, ost_d;
  logic [CW-1:0] opos_q, opos_d, oub_q, oub_d, obytes_q, obytes_d, olf_q, olf_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wdata, rdata;
  logic [SW-1:0] rd_size, nxt_cur, t_pos, end_pos;
  logic          rd_free;
  logic [CW-1:0] cur_c, arena_c, size_c, pay_c, req_c, uoff_c, cfg_c, eff_c;
  logic          at_end, fits, split;

  ffha_ram #(.W(HW), .D(ARENA_BYTES)) u_hdr (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_size = rdata[SW-1:0];
  assign rd_free = rdata[SW];
  assign cur_c   = CW'(cur_q);
  assign arena_c = CW'(arena_q);
  assign size_c  = CW'(rd_size);
  assign pay_c   = size_c - HB;
  assign req_c   = CW'(req_q);
  assign uoff_c  = CW'(user_offset_i);
  assign cfg_c   = CW'(arena_size_i);
  assign eff_c   = (cfg_c < CW'(16)) ? CW'(16) :
                   ((cfg_c > CW'(ARENA_BYTES)) ? CW'(ARENA_BYTES) : cfg_c);
  assign nxt_cur = cur_q + rd_size;
  assign at_end  = (cur_c >= arena_c) || (size_c < HB);
  assign fits    = rd_free && (pay_c >= req_c);
  assign split   = (pay_c - req_c) >= HB;
  assign t_pos   = SW'(cur_c + HB + req_c);
  assign end_pos = nxt_cur;

  always_comb begin
    state_d  = state_q;
    arena_d  = arena_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    psz_d    = psz_q;
    pfree_d  = pfree_q;
    tgt_d    = tgt_q;
    bsz_d    = bsz_q;
    hnext_d  = hnext_q;
    mode_d   = mode_q;
    req_d    = req_q;
    st_d     = st_q;
    pos_d    = pos_q;
    ub_d     = ub_q;
    ubytes_d = ubytes_q;
    lf_d     = lf_q;
    rv_d     = 1'b0;
    ost_d    = ost_q;
    opos_d   = opos_q;
    oub_d    = oub_q;
    obytes_d = obytes_q;
    olf_d    = olf_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = {1'b1, arena_q};
    raddr    = '0;

    unique case (state_q)
      S_INIT: begin
        we = 1'b1;
        if (arena_size_we_i) begin
          arena_d = SW'(eff_c);
          wdata   = {1'b1, SW'(eff_c)};
        end
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (arena_size_we_i) begin
          arena_d = SW'(eff_c);
          we      = 1'b1;
          wdata   = {1'b1, SW'(eff_c)};
        end else if (start) begin
          mode_d  = mode_i;
          req_d   = req_size_i;
          cur_d   = '0;
          prev_d  = '0;
          pfree_d = 1'b0;
          st_d    = ST_OK;
          pos_d   = '0;
          tgt_d   = SW'(uoff_c - HB);
          state_d = S_OPW;
          if (mode_i == MODE_FREE && !(uoff_c < arena_c && uoff_c >= HB)) begin
            st_d    = ST_BAD;
            state_d = S_SISS;
          end
        end
      end
      S_OPW: begin
        if (mode_q == MODE_ALLOC) begin
          if (at_end) begin
            st_d    = ST_NO_FIT;
            state_d = S_SISS;
          end else if (fits) begin
            pos_d   = cur_c + HB;
            we      = 1'b1;
            state_d = S_SISS;
            if (split) begin
              waddr   = t_pos[AW-1:0];
              wdata   = {1'b1, end_pos - t_pos};
              bsz_d   = t_pos - cur_q;
              tgt_d   = cur_q;
              state_d = S_SPLIT;
            end else begin
              waddr = cur_q[AW-1:0];
              wdata = {1'b0, rd_size};
            end
          end else begin
            raddr = nxt_cur[AW-1:0];
            cur_d = nxt_cur;
          end
        end else begin
          if (at_end || cur_q > tgt_q || (cur_q == tgt_q && rd_free)) begin
            st_d    = ST_BAD;
            state_d = S_SISS;
          end else if (cur_q == tgt_q) begin
            bsz_d   = rd_size;
            hnext_d = CW'(nxt_cur) < arena_c;
            raddr   = nxt_cur[AW-1:0];
            state_d = S_FNEXT;
          end else begin
            prev_d  = cur_q;
            psz_d   = rd_size;
            pfree_d = rd_free;
            raddr   = nxt_cur[AW-1:0];
            cur_d   = nxt_cur;
          end
        end
      end
      S_SPLIT: begin
        we      = 1'b1;
        waddr   = tgt_q[AW-1:0];
        wdata   = {1'b0, bsz_q};
        state_d = S_SISS;
      end
      S_FNEXT: begin
        we      = 1'b1;
        state_d = S_SISS;
        if (pfree_q && tgt_q != '0) begin
          waddr = prev_q[AW-1:0];
          if (hnext_q && rd_free) begin
            wdata = {1'b1, psz_q + bsz_q + rd_size};
          end else begin
            wdata = {1'b1, psz_q + bsz_q};
          end
        end else begin
          waddr = tgt_q[AW-1:0];
          if (hnext_q && rd_free) begin
            wdata = {1'b1, bsz_q + rd_size};
          end else begin
            wdata = {1'b1, bsz_q};
          end
        end
      end
      S_SISS: begin
        cur_d    = '0;
        ub_d     = '0;
        ubytes_d = '0;
        lf_d     = '0;
        state_d  = S_STW;
      end
      S_STW: begin
        if (at_end) begin
          rv_d     = 1'b1;
          ost_d    = st_q;
          opos_d   = pos_q;
          oub_d    = ub_q;
          obytes_d = ubytes_q;
          olf_d    = lf_q;
          state_d  = S_IDLE;
        end else begin
          if (rd_free) begin
            if (pay_c > lf_q) begin
              lf_d = pay_c;
            end
          end else begin
            ub_d     = ub_q + CW'(1);
            ubytes_d = ubytes_q + pay_c;
          end
          raddr = nxt_cur[AW-1:0];
          cur_d = nxt_cur;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      arena_q <= RST_ARENA;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      arena_q <= arena_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    psz_q    <= psz_d;
    pfree_q  <= pfree_d;
    tgt_q    <= tgt_d;
    bsz_q    <= bsz_d;
    hnext_q  <= hnext_d;
    mode_q   <= mode_d;
    req_q    <= req_d;
    st_q     <= st_d;
    pos_q    <= pos_d;
    ub_q     <= ub_d;
    ubytes_q <= ubytes_d;
    lf_q     <= lf_d;
    ost_q    <= ost_d;
    opos_q   <= opos_d;
    oub_q    <= oub_d;
    obytes_q <= obytes_d;
    olf_q    <= olf_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = rv_q;
  assign status_o       = ost_q;
  assign position_o     = opos_q[11:0];
  assign used_blocks_o  = oub_q[9:0];
  assign used_bytes_o   = obytes_q[12:0];
  assign largest_free_o = olf_q[12:0];

endmodule

// ===== rtl/ffha_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker import ffha_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        arena_size_we_i,
  input logic [12:0] arena_size_i,
  input logic        start,
  input logic        busy,
  input logic        mode_i,
  input logic [12:0] req_size_i,
  input logic [11:0] user_offset_i,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [11:0] position_o,
  input logic [9:0]  used_blocks_o,
  input logic [12:0] used_bytes_o,
  input logic [12:0] largest_free_o
);

  `FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `FFHA_ASSERT_SAME(a_result_idle, result_valid_o, !busy)
  `FFHA_ASSERT_NEXT(a_single_pulse, result_valid_o, !result_valid_o)
  `FFHA_ASSERT_SAME(a_fail_no_pos, result_valid_o && status_o != ST_OK, position_o == 12'd0)
  `FFHA_ASSERT_SAME(a_status_code, result_valid_o, status_o != 2'd3)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
